### src/tnwc_pkg.sv
// ----------------------------------------------------------------------------
// tnwc_pkg
// shared types and constants of the newreno congestion window engine
// ----------------------------------------------------------------------------
package tnwc_pkg;

    // event kinds
    localparam logic [1:0] MODE_NEW_ACK = 2'd0;
    localparam logic [1:0] MODE_DUP_ACK = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;
    localparam logic [1:0] MODE_REINIT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SEGMENT_SIZE     = 2'd0;
    localparam logic [1:0] CFG_INITIAL_WINDOW   = 2'd1;
    localparam logic [1:0] CFG_INITIAL_SEQUENCE = 2'd2;

    // configuration reset values
    localparam logic [15:0] MSS_RESET  = 16'd1460;
    localparam logic [31:0] IW_RESET   = 32'd4380;
    localparam logic [31:0] ISEQ_RESET = 32'd0;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // duplicate count that triggers fast retransmit
    localparam logic [7:0] DUP_THRESH = 8'd3;

    // width of acked * mss, one quotient bit per divider step
    localparam int unsigned DIV_STEPS = 48;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] acked_bytes;
        logic [7:0]  dup_count;
        logic [31:0] oldest_unacked;
        logic [31:0] next_to_send;
        logic [31:0] highest_sent;
    } t_in_word;

    typedef struct packed {
        logic [31:0] window;
        logic [31:0] threshold;
        logic        in_recovery;
        logic        retransmit_request;
        logic        send_request;
        logic        clear_dup_count;
    } t_out_word;

endpackage

### src/tcp_newreno_window_control_unit.sv
// ----------------------------------------------------------------------------
// tcp_newreno_window_control_unit
// newreno congestion window engine for one connection, one event at a time
// ----------------------------------------------------------------------------
// Takes one event word (new ack, duplicate ack, timeout, reinit) and returns
// one result word with the window, the threshold, the recovery flag and the
// retransmit / send / clear-duplicate requests. Events are handled one at a
// time and the input is not ready while an event is in work. A new ack in
// congestion avoidance goes through a 32x16 multiply and a restoring
// divider that produces one quotient bit a cycle, and goes from acceptance
// to the result register through a setup step, 48 divider steps, a
// saturating add and the output load. Every other event goes through an
// execute step and the output load.
// Configuration writes are always accepted. The segment size acts at once,
// the initial window and sequence only at reset or on a reinit event.
// ----------------------------------------------------------------------------
module tcp_newreno_window_control_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tnwc_pkg::t_in_word   i_in_data,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tnwc_pkg::t_out_word  o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [5:0] LAST_STEP = 6'(tnwc_pkg::DIV_STEPS - 1);

    // control and connection state
    logic [2:0]  r_state, n_state;
    logic [31:0] r_cwnd, n_cwnd;
    logic [31:0] r_ssth, n_ssth;
    logic [31:0] r_rpt, n_rpt;
    logic        r_rec, n_rec;
    logic        r_retx, n_retx;
    logic        r_send, n_send;
    logic        r_clr, n_clr;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;

    // configuration registers
    logic [15:0] r_mss;
    logic [31:0] r_iw;
    logic [31:0] r_iseq;

    // payload registers
    tnwc_pkg::t_in_word  r_in, n_in;
    tnwc_pkg::t_out_word r_out, n_out;
    logic [47:0] r_quo, n_quo;   // dividend shifts out, quotient shifts in
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_div, n_div;

    // datapath helpers
    logic [31:0] flight;
    logic [31:0] half;
    logic [31:0] floor2;
    logic [31:0] thresh;
    logic [31:0] una_diff;
    logic        beyond;
    logic [31:0] cw_eff;
    logic [17:0] mss3;
    logic [32:0] sum_ack;
    logic [32:0] sum_fr;
    logic [32:0] sum_dup;
    logic [33:0] trial;
    logic [31:0] inc;
    logic [32:0] sum_inc;
    logic        in_acc;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // threshold from the data in flight, never below two segments
    assign flight = r_in.next_to_send - r_in.oldest_unacked;
    assign half   = {1'b0, flight[31:1]};
    assign floor2 = {15'd0, r_mss, 1'b0};
    assign thresh = (half > floor2) ? half : floor2;

    // oldest unacked lies past the recovery point (serial number compare)
    assign una_diff = r_in.oldest_unacked - r_rpt;
    assign beyond   = (una_diff != 32'd0) && !una_diff[31];

    // a new ack first leaves fast recovery and deflates to the threshold
    assign cw_eff = r_rec ? r_ssth : r_cwnd;

    assign mss3    = {1'b0, r_mss, 1'b0} + {2'b00, r_mss};
    assign sum_ack = {1'b0, cw_eff} + {1'b0, r_in.acked_bytes};
    assign sum_fr  = {1'b0, thresh} + {15'd0, mss3};
    assign sum_dup = {1'b0, r_cwnd} + {17'd0, r_mss};

    // one restoring divider step
    assign trial = {1'b0, r_rem, r_quo[47]} - {2'b00, r_div};

    // avoidance growth is at least one byte
    assign inc     = (r_quo[31:0] == 32'd0) ? 32'd1 : r_quo[31:0];
    assign sum_inc = {1'b0, r_cwnd} + {1'b0, inc};

    always_comb begin
        n_state     = r_state;
        n_cwnd      = r_cwnd;
        n_ssth      = r_ssth;
        n_rpt       = r_rpt;
        n_rec       = r_rec;
        n_retx      = r_retx;
        n_send      = r_send;
        n_clr       = r_clr;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_in        = r_in;
        n_out       = r_out;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;

        // result word taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_in    = i_in_data;
                    n_retx  = 1'b0;
                    n_send  = 1'b0;
                    n_clr   = 1'b0;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state = ST_DONE;
                unique case (r_in.mode)
                    tnwc_pkg::MODE_NEW_ACK: begin
                        n_rec  = 1'b0;
                        n_cwnd = cw_eff;
                        if (cw_eff < r_ssth) begin
                            // slow start
                            n_cwnd = sum_ack[32] ? tnwc_pkg::ALL_ONES : sum_ack[31:0];
                        end else begin
                            // congestion avoidance: acked * mss / window
                            n_quo   = {16'd0, r_in.acked_bytes} * {32'd0, r_mss};
                            n_rem   = 32'd0;
                            n_div   = (cw_eff == 32'd0) ? 32'd1 : cw_eff;
                            n_cnt   = 6'd0;
                            n_state = ST_DIV;
                        end
                    end
                    tnwc_pkg::MODE_DUP_ACK: begin
                        if (r_in.dup_count == tnwc_pkg::DUP_THRESH) begin
                            // fast retransmit, enter fast recovery
                            if (beyond) begin
                                n_rpt  = r_in.highest_sent;
                                n_ssth = thresh;
                                n_cwnd = sum_fr[32] ? tnwc_pkg::ALL_ONES : sum_fr[31:0];
                                n_rec  = 1'b1;
                                n_retx = 1'b1;
                            end
                        end else if ((r_in.dup_count > tnwc_pkg::DUP_THRESH) && r_rec) begin
                            // window inflation by one segment
                            n_cwnd = sum_dup[32] ? tnwc_pkg::ALL_ONES : sum_dup[31:0];
                            n_send = 1'b1;
                        end
                    end
                    tnwc_pkg::MODE_TIMEOUT: begin
                        n_ssth = thresh;
                        n_cwnd = {16'd0, r_mss};
                        n_rec  = 1'b0;
                        n_rpt  = r_in.oldest_unacked;
                        n_clr  = 1'b1;
                    end
                    tnwc_pkg::MODE_REINIT: begin
                        n_cwnd = r_iw;
                        n_ssth = tnwc_pkg::ALL_ONES;
                        n_rpt  = r_iseq;
                        n_rec  = 1'b0;
                        n_clr  = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            ST_DIV: begin
                if (!trial[33]) begin
                    n_rem = trial[31:0];
                end else begin
                    n_rem = {r_rem[30:0], r_quo[47]};
                end
                n_quo = {r_quo[46:0], !trial[33]};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_ADD;
                end
            end

            ST_ADD: begin
                // quotient beyond 32 bits saturates the window anyway
                if ((r_quo[47:32] != 16'd0) || sum_inc[32]) begin
                    n_cwnd = tnwc_pkg::ALL_ONES;
                end else begin
                    n_cwnd = sum_inc[31:0];
                end
                n_state = ST_DONE;
            end

            ST_DONE: begin
                // wait for the result register to be free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid              = 1'b1;
                    n_out.window             = r_cwnd;
                    n_out.threshold          = r_ssth;
                    n_out.in_recovery        = r_rec;
                    n_out.retransmit_request = r_retx;
                    n_out.send_request       = r_send;
                    n_out.clear_dup_count    = r_clr;
                    n_state                  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state and connection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            // reset window follows the reset value of the initial window register
            r_cwnd      <= tnwc_pkg::IW_RESET;
            r_ssth      <= tnwc_pkg::ALL_ONES;
            r_rpt       <= tnwc_pkg::ISEQ_RESET;
            r_rec       <= 1'b0;
            r_retx      <= 1'b0;
            r_send      <= 1'b0;
            r_clr       <= 1'b0;
            r_cnt       <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cwnd      <= n_cwnd;
            r_ssth      <= n_ssth;
            r_rpt       <= n_rpt;
            r_rec       <= n_rec;
            r_retx      <= n_retx;
            r_send      <= n_send;
            r_clr       <= n_clr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss  <= tnwc_pkg::MSS_RESET;
            r_iw   <= tnwc_pkg::IW_RESET;
            r_iseq <= tnwc_pkg::ISEQ_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tnwc_pkg::CFG_SEGMENT_SIZE:     r_mss  <= i_cfg_data[15:0];
                tnwc_pkg::CFG_INITIAL_WINDOW:   r_iw   <= i_cfg_data;
                tnwc_pkg::CFG_INITIAL_SEQUENCE: r_iseq <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // an accepted event word is not followed by another in the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("event word accepted while the previous one is in work");

    // the partial remainder always stays below the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    // the divisor is never zero while dividing
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_div != 32'd0))
        else $error("divider running with zero divisor");

    // a retransmit request always comes with fast recovery entered
    a_retx_in_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.retransmit_request) |-> o_out_data.in_recovery)
        else $error("retransmit request outside fast recovery");

    // at most one request kind per result word
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_out_data.retransmit_request,
                                  o_out_data.send_request,
                                  o_out_data.clear_dup_count}))
        else $error("more than one request in a result word");

endmodule

### tb/sv/tcp_newreno_window_control_unit_check.sv
// ----------------------------------------------------------------------------
// tcp_newreno_window_control_unit_check
// watches the event, result and configuration channels of the window engine
// ----------------------------------------------------------------------------
// Keeps its own copy of the configuration registers and of the congestion
// state, works out the result word of every accepted event word and compares
// each accepted result word, field by field, with the oldest one outstanding.
// Hands the number of outstanding results and the error count to the top.
// ----------------------------------------------------------------------------
module tcp_newreno_window_control_unit_check
    import tnwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_word   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_word  i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int         o_pending,
    output int         o_errors
);

    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic [15:0] seg_size     = MSS_RESET;
    logic [31:0] start_window = IW_RESET;
    logic [31:0] start_seq    = ISEQ_RESET;

    // congestion state
    logic [31:0] cwnd          = IW_RESET;
    logic [31:0] ssthresh      = ALL_ONES;
    logic [31:0] recovery_seq  = ISEQ_RESET;
    logic        recovering    = 1'b0;

    t_out_word expected_words[$];
    int        errors = 0;

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [63:0] b);
        logic [63:0] s;
        s = {32'd0, a} + b;
        return (s > {32'd0, ALL_ONES}) ? ALL_ONES : s[31:0];
    endfunction

    // max(flight / 2, 2 * mss), flight taken modulo 2^32
    function automatic logic [31:0] flight_threshold(logic [31:0] una, logic [31:0] nxt);
        logic [31:0] half;
        logic [31:0] floor2;
        half   = (nxt - una) >> 1;
        floor2 = {15'd0, seg_size, 1'b0};
        return (half > floor2) ? half : floor2;
    endfunction

    function automatic void load_start_state();
        cwnd          = start_window;
        ssthresh      = ALL_ONES;
        recovery_seq  = start_seq;
        recovering    = 1'b0;
    endfunction

    // applies one event to the state and returns the result word it causes
    function automatic t_out_word advance_window(t_in_word ev);
        t_out_word   res;
        logic [31:0] gap;
        logic [63:0] grow;
        logic [63:0] divisor;
        res = '0;
        case (ev.mode)
            MODE_NEW_ACK: begin
                if (recovering) begin
                    cwnd          = ssthresh;
                    recovering    = 1'b0;
                end
                if (cwnd < ssthresh) begin
                    cwnd = sat_sum(cwnd, {32'd0, ev.acked_bytes});
                end else begin
                    divisor = (cwnd == 32'd0) ? 64'd1 : {32'd0, cwnd};
                    grow    = ({32'd0, ev.acked_bytes} * {48'd0, seg_size}) / divisor;
                    if (grow == 64'd0) begin
                        grow = 64'd1;
                    end
                    cwnd = sat_sum(cwnd, grow);
                end
            end
            MODE_DUP_ACK: begin
                gap = ev.oldest_unacked - recovery_seq;
                if (ev.dup_count == DUP_THRESH) begin
                    // only past the recovery point, in serial number order
                    if (gap != 32'd0 && !gap[31]) begin
                        recovery_seq  = ev.highest_sent;
                        ssthresh      = flight_threshold(ev.oldest_unacked, ev.next_to_send);
                        cwnd          = sat_sum(ssthresh, 64'd3 * {48'd0, seg_size});
                        recovering    = 1'b1;
                        res.retransmit_request = 1'b1;
                    end
                end else if (ev.dup_count > DUP_THRESH && recovering) begin
                    cwnd = sat_sum(cwnd, {48'd0, seg_size});
                    res.send_request = 1'b1;
                end
            end
            MODE_TIMEOUT: begin
                ssthresh      = flight_threshold(ev.oldest_unacked, ev.next_to_send);
                cwnd          = {16'd0, seg_size};
                recovering    = 1'b0;
                recovery_seq  = ev.oldest_unacked;
                res.clear_dup_count = 1'b1;
            end
            default: begin
                load_start_state();
                res.clear_dup_count = 1'b1;
            end
        endcase
        res.window      = cwnd;
        res.threshold   = ssthresh;
        res.in_recovery = recovering;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%t ERROR %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            seg_size     = MSS_RESET;
            start_window = IW_RESET;
            start_seq    = ISEQ_RESET;
            load_start_state();
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEGMENT_SIZE:     seg_size     = i_cfg_data[15:0];
                    CFG_INITIAL_WINDOW:   start_window = i_cfg_data;
                    CFG_INITIAL_SEQUENCE: start_seq    = i_cfg_data;
                    default: ;
                endcase
            end
            // result before event: a word accepted now cannot leave this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%t ERROR result word with nothing outstanding: %h",
                             $time, i_out_data);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    compare_field("window", want.window, i_out_data.window);
                    compare_field("threshold", want.threshold, i_out_data.threshold);
                    compare_field("in_recovery", 32'(want.in_recovery),
                                  32'(i_out_data.in_recovery));
                    compare_field("retransmit_request", 32'(want.retransmit_request),
                                  32'(i_out_data.retransmit_request));
                    compare_field("send_request", 32'(want.send_request),
                                  32'(i_out_data.send_request));
                    compare_field("clear_dup_count", 32'(want.clear_dup_count),
                                  32'(i_out_data.clear_dup_count));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_words.push_back(advance_window(i_in_data));
            end
        end
        o_pending <= expected_words.size();
        o_errors  <= errors;
    end

endmodule

### tb/sv/tcp_newreno_window_control_unit_test.sv
// ----------------------------------------------------------------------------
// tcp_newreno_window_control_unit_test
// stimulus and verdict for the newreno congestion window engine
// ----------------------------------------------------------------------------
// A short directed run covers the saturating sums, the minimum avoidance
// step, the recovery point compare at its edges, the zero segment size and
// the zero window divisor. Then random traffic shaped like a real sender
// (acks advancing snd_una, duplicate ack runs, timeouts, reinits, plus some
// fully random words) runs under several register settings and three
// idling patterns. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tcp_newreno_window_control_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tnwc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000; // cycles with no handshake at all
    localparam int unsigned HOLD_CYCLES    = 400;  // one long receiver hold-off
    localparam int unsigned SETTLE_CYCLES  = 60;   // beyond the avoidance path
    localparam int unsigned CHUNK_WORDS    = 220;  // random words per register setting

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    // block inputs, known from time zero
    logic        i_in_valid  = 1'b0;
    t_in_word    i_in_data   = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_SEGMENT_SIZE;
    logic [31:0] i_cfg_data  = '0;

    // block outputs
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_data;
    logic      o_cfg_ready;

    // from the checker
    int pending;
    int error_count;

    // idling pattern, percent of cycles each side holds back
    int unsigned in_idle_pct  = 15;
    int unsigned out_idle_pct = 57;
    logic        pressure_on  = 1'b0;

    // sender view of the connection, used to shape well-formed traffic
    logic [31:0] snd_una;
    logic [31:0] snd_nxt;
    logic [31:0] snd_max;
    logic [7:0]  dup_run;
    logic [15:0] cur_mss  = MSS_RESET;
    logic [31:0] cur_iseq = ISEQ_RESET;

    // run statistics
    int events_sent    = 0;
    int settings_count = 0;
    int mode_count[4]  = '{default: 0};

    tcp_newreno_window_control_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tcp_newreno_window_control_unit_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (error_count)
    );

    // result side: random stalls, plus one long hold-off once pressure is asked for
    int   hold_left     = 0;
    logic pressure_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (pressure_on && !pressure_done) begin
            // the sender keeps offering words, so the block backs up to its input
            i_out_ready   <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // watchdog: any stretch with no handshake on any channel is bounded
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("%t watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tcp_newreno_window_control_unit: mismatch");
                $finish;
            end
        end
    end

    function automatic t_in_word make_event(logic [1:0] mode, logic [31:0] acked,
                                            logic [7:0] dups, logic [31:0] una,
                                            logic [31:0] nxt, logic [31:0] smax);
        t_in_word ev;
        ev.mode           = mode;
        ev.acked_bytes    = acked;
        ev.dup_count      = dups;
        ev.oldest_unacked = una;
        ev.next_to_send   = nxt;
        ev.highest_sent   = smax;
        return ev;
    endfunction

    // offers one event word and returns in the step it is taken;
    // valid stays up across back to back words
    task automatic send_word(input t_in_word ev);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        events_sent++;
        mode_count[ev.mode]++;
    endtask

    // every event gives one result word, so an empty queue means idle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // the new window and sequence only reach the state on the next reinit
    task automatic load_settings(input logic [15:0] mss, input logic [31:0] iw,
                                 input logic [31:0] iseq);
        write_reg(CFG_SEGMENT_SIZE, {16'd0, mss});
        write_reg(CFG_INITIAL_WINDOW, iw);
        write_reg(CFG_INITIAL_SEQUENCE, iseq);
        i_cfg_valid <= 1'b0;
        cur_mss  = mss;
        cur_iseq = iseq;
        settings_count++;
    endtask

    // random traffic: mostly a plausible sender, with some noise words
    task automatic gen_traffic(input int count);
        int          first;
        int unsigned pick;
        int unsigned burst;
        logic [31:0] acked;
        first = events_sent;
        while (events_sent - first < count) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                // new ack: mostly whole segments, some partial, a few wild
                pick = $urandom_range(19);
                if (pick < 14) begin
                    acked = 32'(cur_mss) * $urandom_range(1, 4);
                end else if (pick < 17) begin
                    acked = $urandom_range(0, cur_mss);
                end else begin
                    acked = $urandom;
                end
                snd_una = snd_una + acked;
                if (snd_nxt - snd_una >= 32'h8000_0000) begin
                    snd_nxt = snd_una;
                end
                snd_nxt = snd_nxt + 32'(cur_mss) * $urandom_range(0, 16);
                if (snd_nxt - snd_max < 32'h8000_0000) begin
                    snd_max = snd_nxt;
                end
                dup_run = 8'd0;
                send_word(make_event(MODE_NEW_ACK, acked, dup_run, snd_una, snd_nxt,
                                     snd_max));
            end else if (pick < 78) begin
                // duplicate ack run, now and then near the counter's ceiling
                burst = $urandom_range(1, 6);
                if ($urandom_range(15) == 0) begin
                    dup_run = 8'($urandom_range(248, 254));
                end
                repeat (burst) begin
                    if (dup_run != 8'hFF) begin
                        dup_run = dup_run + 8'd1;
                    end
                    send_word(make_event(MODE_DUP_ACK, 32'd0, dup_run, snd_una, snd_nxt,
                                         snd_max));
                end
            end else if (pick < 85) begin
                send_word(make_event(MODE_TIMEOUT, 32'd0, dup_run, snd_una, snd_nxt,
                                     snd_max));
                // go back to the oldest unacked byte
                dup_run = 8'd0;
                snd_nxt = snd_una;
            end else if (pick < 88) begin
                send_word(make_event(MODE_REINIT, $urandom, dup_run, snd_una, snd_nxt,
                                     snd_max));
                snd_una = cur_iseq;
                snd_nxt = cur_iseq;
                snd_max = cur_iseq;
                dup_run = 8'd0;
            end else begin
                send_word(make_event(2'($urandom_range(3)), $urandom, 8'($urandom),
                                     $urandom, $urandom, $urandom));
            end
        end
    endtask

    initial begin
        int unsigned pick;
        logic [15:0] mss;
        logic [31:0] iw;
        logic [31:0] iseq;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values (mss 1460, window 4380, sequence 0)
        send_word(make_event(MODE_NEW_ACK, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0));
        // slow start sum saturates
        send_word(make_event(MODE_NEW_ACK, ALL_ONES, 8'd0, ALL_ONES, ALL_ONES, ALL_ONES));
        // avoidance on a saturated window saturates again
        send_word(make_event(MODE_NEW_ACK, ALL_ONES, 8'd0, 32'd0, 32'd0, 32'd0));
        // third duplicate level with the recovery point, then half way round
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd3, 32'd0, 32'd100, 32'd100));
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd3, 32'h8000_0000, 32'h8000_0100,
                             32'h8000_0100));
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd2, 32'd1000, 32'd2000, 32'd2000));
        // later duplicate outside recovery does nothing
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd4, 32'd1000, 32'd2000, 32'd2000));
        // furthest point still ahead of the recovery point: fast retransmit
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd3, 32'h7FFF_FFFF, 32'h8001_86A0,
                             32'h8002_0000));
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd4, 32'h7FFF_FFFF, 32'h8001_86A0,
                             32'h8002_0000));
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd255, 32'h7FFF_FFFF, 32'h8001_86A0,
                             32'h8002_0000));
        // third duplicate again, behind the new recovery point
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd3, 32'h7FFF_FFFF, 32'h8001_86A0,
                             32'h8002_0000));
        // leaves recovery with deflation, then the one byte minimum step
        send_word(make_event(MODE_NEW_ACK, 32'd5000, 8'd0, 32'h8000_1387, 32'h8001_86A0,
                             32'h8002_0000));
        send_word(make_event(MODE_NEW_ACK, 32'd1, 8'd0, 32'h8000_1388, 32'h8001_86A0,
                             32'h8002_0000));
        // timeouts: no flight, flight across the wrap, largest flight
        send_word(make_event(MODE_TIMEOUT, 32'd0, 8'd7, 32'd5, 32'd5, 32'd5));
        send_word(make_event(MODE_NEW_ACK, 32'd0, 8'd0, 32'd5, 32'd5, 32'd5));
        send_word(make_event(MODE_TIMEOUT, 32'd0, 8'd0, 32'hFFFF_FF00, 32'h0000_0100,
                             32'h0000_0100));
        send_word(make_event(MODE_TIMEOUT, 32'd0, 8'd0, 32'd0, ALL_ONES, ALL_ONES));
        send_word(make_event(MODE_REINIT, ALL_ONES, 8'hFF, ALL_ONES, ALL_ONES, ALL_ONES));
        send_word(make_event(MODE_DUP_ACK, ALL_ONES, 8'hFF, ALL_ONES, ALL_ONES, ALL_ONES));

        // zero segment size: a timeout with no flight leaves window and threshold at zero
        wait_drained();
        load_settings(16'd0, ALL_ONES, 32'h7FFF_FFFF);
        send_word(make_event(MODE_REINIT, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0));
        send_word(make_event(MODE_TIMEOUT, 32'd0, 8'd0, 32'h1234, 32'h1234, 32'h1234));
        // largest segment: zero window divisor and the full width product
        wait_drained();
        load_settings(16'hFFFF, 32'd1, ALL_ONES);
        send_word(make_event(MODE_NEW_ACK, ALL_ONES, 8'd0, 32'h1234, 32'h1234, 32'h1234));
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd3, 32'h2000, 32'h2000, 32'h3000));
        // recovery point one below zero, so zero is just ahead of it
        send_word(make_event(MODE_REINIT, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0));
        send_word(make_event(MODE_DUP_ACK, 32'd0, 8'd3, 32'd0, 32'h1_0000, 32'h1_0000));

        // random traffic: three idling patterns, three register settings each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct  <= 15;
                    out_idle_pct <= 57;
                end
                1: begin
                    in_idle_pct  <= 57;
                    out_idle_pct <= 15;
                end
                default: begin
                    in_idle_pct  <= 0;
                    out_idle_pct <= 0;
                end
            endcase
            for (int chunk = 0; chunk < 3; chunk++) begin
                wait_drained();
                case (phase * 3 + chunk)
                    0: begin
                        mss  = 16'd536;
                        iw   = 32'd1;
                        iseq = $urandom;
                    end
                    4: begin
                        mss  = 16'hFFFF;
                        iw   = ALL_ONES;
                        iseq = 32'd0;
                    end
                    8: begin
                        mss  = 16'd1;
                        iw   = $urandom;
                        iseq = ALL_ONES;
                    end
                    default: begin
                        pick = $urandom_range(3);
                        mss  = (pick == 0) ? 16'd536 : (pick == 1) ? 16'd1460 :
                               (pick == 2) ? 16'd8960 : 16'($urandom_range(1, 65535));
                        iw   = 32'(mss) * $urandom_range(1, 10);
                        iseq = $urandom;
                    end
                endcase
                load_settings(mss, iw, iseq);
                snd_una = iseq;
                snd_nxt = iseq;
                snd_max = iseq;
                dup_run = 8'd0;
                send_word(make_event(MODE_REINIT, 32'd0, 8'd0, iseq, iseq, iseq));
                // long receiver hold-off while words keep coming, last phase only
                if (phase == 2 && chunk == 0) begin
                    pressure_on <= 1'b1;
                end
                gen_traffic(CHUNK_WORDS);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d event words: %0d new ack, %0d duplicate ack, %0d timeout, %0d reinit",
                 events_sent, mode_count[MODE_NEW_ACK], mode_count[MODE_DUP_ACK],
                 mode_count[MODE_TIMEOUT], mode_count[MODE_REINIT]);
        $display("under %0d register settings, three idling patterns and one %0d cycle hold-off",
                 settings_count, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("tcp_newreno_window_control_unit: match");
        end else begin
            $display("tcp_newreno_window_control_unit: mismatch");
        end
        $finish;
    end

endmodule
